/* src/hb_pkg.sv */
package hb_pkg;

  localparam int SYMBOLS     = 256;
  localparam int COUNT_BITS  = 32;
  localparam int WEIGHT_BITS = 40;
  localparam int LEAF_SLOTS  = 256;
  localparam int NODE_SLOTS  = 512;
  localparam int LEAF_BITS   = $clog2(LEAF_SLOTS);
  localparam int IDX_BITS    = $clog2(NODE_SLOTS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [LEAF_BITS-1:0]   leaf_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_COUNT  = 10'b00_0000_0010,
    ST_LOAD   = 10'b00_0000_0100,
    ST_DECIDE = 10'b00_0000_1000,
    ST_SCAN   = 10'b00_0001_0000,
    ST_KILL_A = 10'b00_0010_0000,
    ST_KILL_B = 10'b00_0100_0000,
    ST_MERGE  = 10'b00_1000_0000,
    ST_FINISH = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_init;
    logic count_wr;
    logic load_run;
    logic scan_init;
    logic scan_run;
    logic kill_a;
    logic kill_b;
    logic merge;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic scan_done;
    logic multi_live;
    logic out_free;
  } sts_t;

  typedef struct packed {
    idx_t                 root_index;
    logic                 tree_empty;
    logic [LEAF_BITS-1:0] internal_count;
    idx_t                 child_zero;
    idx_t                 child_one;
    weight_t              node_weight;
    logic                 node_is_leaf;
    logic                 leaf_in_tree;
  } result_t;

endpackage

/* src/hb_in_if.sv */
interface hb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] byte_value;
  logic [8:0] node_index;

  modport source (output valid, output mode, output byte_value, output node_index,
                  input ready);
  modport sink   (input valid, input mode, input byte_value, input node_index,
                  output ready);
endinterface

/* src/hb_out_if.sv */
interface hb_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  root_index;
  logic        tree_empty;
  logic [7:0]  internal_count;
  logic [8:0]  child_zero;
  logic [8:0]  child_one;
  logic [39:0] node_weight;
  logic        node_is_leaf;
  logic        leaf_in_tree;

  modport source (output valid, output root_index, output tree_empty,
                  output internal_count, output child_zero, output child_one,
                  output node_weight, output node_is_leaf, output leaf_in_tree,
                  input ready);
  modport sink   (input valid, input root_index, input tree_empty,
                  input internal_count, input child_zero, input child_one,
                  input node_weight, input node_is_leaf, input leaf_in_tree,
                  output ready);
endinterface

/* src/hb_ctrl.sv */
module hb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  input  hb_pkg::sts_t  sts,
  output logic          in_ready,
  output hb_pkg::cmd_t  cmd
);

  hb_pkg::state_t state_r, state_nxt;
  hb_pkg::mode_t  mode;
  logic           accept;

  assign mode     = hb_pkg::mode_t'(in_mode);
  assign in_ready = (state_r == hb_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.load_init = accept && (mode == hb_pkg::MODE_BUILD);
    cmd.count_wr  = (state_r == hb_pkg::ST_COUNT);
    cmd.load_run  = (state_r == hb_pkg::ST_LOAD);
    cmd.scan_init = (state_r == hb_pkg::ST_DECIDE) && sts.multi_live;
    cmd.scan_run  = (state_r == hb_pkg::ST_SCAN);
    cmd.kill_a    = (state_r == hb_pkg::ST_KILL_A);
    cmd.kill_b    = (state_r == hb_pkg::ST_KILL_B);
    cmd.merge     = (state_r == hb_pkg::ST_MERGE);
    cmd.finish    = (state_r == hb_pkg::ST_FINISH);
    cmd.out_load  = (state_r == hb_pkg::ST_OUT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            hb_pkg::MODE_COUNT: state_nxt = hb_pkg::ST_COUNT;
            hb_pkg::MODE_BUILD: state_nxt = hb_pkg::ST_LOAD;
            hb_pkg::MODE_READ:  state_nxt = hb_pkg::ST_OUT;
            hb_pkg::MODE_NONE:  state_nxt = hb_pkg::ST_IDLE;
          endcase
        end
      end
      hb_pkg::ST_COUNT:  state_nxt = hb_pkg::ST_IDLE;
      hb_pkg::ST_LOAD:   if (sts.load_done) state_nxt = hb_pkg::ST_DECIDE;
      hb_pkg::ST_DECIDE: state_nxt = sts.multi_live ? hb_pkg::ST_SCAN : hb_pkg::ST_FINISH;
      hb_pkg::ST_SCAN:   if (sts.scan_done) state_nxt = hb_pkg::ST_KILL_A;
      hb_pkg::ST_KILL_A: state_nxt = hb_pkg::ST_KILL_B;
      hb_pkg::ST_KILL_B: state_nxt = hb_pkg::ST_MERGE;
      hb_pkg::ST_MERGE:  state_nxt = hb_pkg::ST_DECIDE;
      hb_pkg::ST_FINISH: state_nxt = hb_pkg::ST_OUT;
      hb_pkg::ST_OUT:    if (sts.out_free) state_nxt = hb_pkg::ST_IDLE;
      default:           state_nxt = hb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/hb_datapath.sv */
module hb_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  hb_pkg::cmd_t     cmd,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_byte,
  input  logic [8:0]       in_node,
  input  logic             out_ready,
  output hb_pkg::sts_t     sts,
  output logic             out_valid,
  output hb_pkg::result_t  out_res
);

  // storage
  hb_pkg::count_t              cnt_mem [hb_pkg::LEAF_SLOTS];
  logic [hb_pkg::LEAF_SLOTS-1:0] cnt_vld_r;
  logic [hb_pkg::WEIGHT_BITS:0]  wt_mem [hb_pkg::NODE_SLOTS];   // {live, weight}
  logic [2*hb_pkg::IDX_BITS-1:0] ch_mem [hb_pkg::LEAF_SLOTS];   // {child1, child0}

  hb_pkg::count_t               cnt_q_r;
  logic                         cnt_vq_r;
  logic [hb_pkg::WEIGHT_BITS:0] wq_r;
  logic [2*hb_pkg::IDX_BITS-1:0] chq_r;

  hb_pkg::mode_t   mode_r;
  hb_pkg::leaf_t   byte_r;
  hb_pkg::idx_t    node_r;

  // load and build bookkeeping
  hb_pkg::idx_t    ld_addr_r;
  logic            pv_r;
  hb_pkg::leaf_t   pidx_r;
  hb_pkg::idx_t    alive_r;
  hb_pkg::idx_t    last_r;
  hb_pkg::leaf_t   made_r;

  // scan for the two lightest live nodes
  hb_pkg::idx_t    sc_addr_r, sc_last_r, sidx_r;
  logic            sc_end_r, sv_r;
  logic            f1_r, f2_r;
  hb_pkg::idx_t    m1_r, m2_r;
  hb_pkg::weight_t w1_r, w2_r;

  hb_pkg::idx_t    root_r;
  logic            empty_r;
  hb_pkg::leaf_t   total_r;
  logic            built_r;

  logic            out_valid_r;
  hb_pkg::result_t out_res_r, res_nxt;

  hb_pkg::leaf_t   cnt_raddr;
  logic            cnt_re;
  hb_pkg::count_t  cnt_cur;
  hb_pkg::idx_t    wt_raddr;
  logic            wt_re;
  logic            wt_we;
  hb_pkg::idx_t    wt_waddr;
  logic [hb_pkg::WEIGHT_BITS:0] wt_wdata;
  hb_pkg::weight_t lw;
  logic [hb_pkg::WEIGHT_BITS:0] sum;
  hb_pkg::weight_t sum_sat;
  hb_pkg::weight_t cur_w;
  logic            cur_live;

  assign cnt_raddr = cmd.capture ? in_byte : ld_addr_r[hb_pkg::LEAF_BITS-1:0];
  assign cnt_re    = cmd.capture || cmd.load_run;
  assign cnt_cur   = cnt_vq_r ? cnt_q_r : '0;
  assign wt_raddr  = cmd.capture ? in_node : sc_addr_r;
  assign wt_re     = cmd.capture || cmd.scan_run;

  assign lw = (cnt_vq_r && ({1'b0, pidx_r} < hb_pkg::IDX_BITS'(hb_pkg::SYMBOLS)))
            ? hb_pkg::WEIGHT_BITS'(cnt_q_r) : '0;
  assign sum     = {1'b0, w1_r} + {1'b0, w2_r};
  assign sum_sat = sum[hb_pkg::WEIGHT_BITS] ? '1 : sum[hb_pkg::WEIGHT_BITS-1:0];
  assign cur_w    = wq_r[hb_pkg::WEIGHT_BITS-1:0];
  assign cur_live = wq_r[hb_pkg::WEIGHT_BITS];

  always_comb begin
    wt_we    = 1'b0;
    wt_waddr = '0;
    wt_wdata = '0;
    priority if (cmd.load_run && pv_r) begin
      wt_we    = 1'b1;
      wt_waddr = {1'b0, pidx_r};
      wt_wdata = {lw != '0, lw};
    end else if (cmd.kill_a) begin
      wt_we    = 1'b1;
      wt_waddr = m1_r;
      wt_wdata = {1'b0, w1_r};
    end else if (cmd.kill_b) begin
      wt_we    = 1'b1;
      wt_waddr = m2_r;
      wt_wdata = {1'b0, w2_r};
    end else if (cmd.merge) begin
      wt_we    = 1'b1;
      wt_waddr = {1'b1, made_r};
      wt_wdata = {1'b1, sum_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_re) begin
      cnt_q_r  <= cnt_mem[cnt_raddr];
      cnt_vq_r <= cnt_vld_r[cnt_raddr];
    end
    if (cmd.count_wr && (cnt_cur != hb_pkg::COUNT_MAX)) cnt_mem[byte_r] <= cnt_cur + 1'b1;
    if (wt_re) wq_r <= wt_mem[wt_raddr];
    if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
    if (cmd.capture) chq_r <= ch_mem[in_node[hb_pkg::LEAF_BITS-1:0]];
    if (cmd.merge) ch_mem[made_r] <= {m2_r, m1_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= hb_pkg::mode_t'(in_mode);
      byte_r <= in_byte;
      node_r <= in_node;
    end
    if (cmd.load_init) begin
      ld_addr_r <= '0;
      pv_r      <= 1'b0;
      alive_r   <= '0;
      last_r    <= '0;
      made_r    <= '0;
    end
    if (cmd.load_run) begin
      if (!ld_addr_r[hb_pkg::LEAF_BITS]) begin
        ld_addr_r <= ld_addr_r + 1'b1;
        pv_r      <= 1'b1;
        pidx_r    <= ld_addr_r[hb_pkg::LEAF_BITS-1:0];
      end else begin
        pv_r <= 1'b0;
      end
      if (pv_r && (lw != '0)) begin
        alive_r <= alive_r + 1'b1;
        last_r  <= {1'b0, pidx_r};
      end
    end
    if (cmd.scan_init) begin
      sc_addr_r <= '0;
      sc_end_r  <= 1'b0;
      sv_r      <= 1'b0;
      f1_r      <= 1'b0;
      f2_r      <= 1'b0;
      sc_last_r <= hb_pkg::IDX_BITS'(hb_pkg::LEAF_SLOTS - 1) + {1'b0, made_r};
    end
    if (cmd.scan_run) begin
      if (!sc_end_r) begin
        sc_addr_r <= sc_addr_r + 1'b1;
        sv_r      <= 1'b1;
        sidx_r    <= sc_addr_r;
        sc_end_r  <= (sc_addr_r == sc_last_r);
      end else begin
        sv_r <= 1'b0;
      end
      // ascending scan with strict compares keeps the lowest index on ties
      if (sv_r && cur_live) begin
        if (!f1_r || (cur_w < w1_r)) begin
          m2_r <= m1_r;
          w2_r <= w1_r;
          f2_r <= f1_r;
          m1_r <= sidx_r;
          w1_r <= cur_w;
          f1_r <= 1'b1;
        end else if (!f2_r || (cur_w < w2_r)) begin
          m2_r <= sidx_r;
          w2_r <= cur_w;
          f2_r <= 1'b1;
        end
      end
    end
    if (cmd.merge) begin
      made_r  <= made_r + 1'b1;
      alive_r <= alive_r - 1'b1;
      last_r  <= {1'b1, made_r};
    end
    if (cmd.out_load) out_res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r   <= '0;
      root_r      <= '0;
      empty_r     <= 1'b1;
      total_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.count_wr) cnt_vld_r[byte_r] <= 1'b1;
      if (cmd.load_run && sts.load_done) cnt_vld_r <= '0;
      if (cmd.finish) begin
        root_r  <= (alive_r == '0) ? '0 : last_r;
        empty_r <= (alive_r == '0);
        total_r <= made_r;
        built_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    res_nxt                = '0;
    res_nxt.root_index     = root_r;
    res_nxt.tree_empty     = empty_r;
    res_nxt.internal_count = total_r;
    if (mode_r == hb_pkg::MODE_READ) begin
      if (!node_r[hb_pkg::LEAF_BITS]) begin
        res_nxt.node_weight  = built_r ? cur_w : '0;
        res_nxt.node_is_leaf = 1'b1;
        res_nxt.leaf_in_tree = built_r && (cur_w != '0);
      end else if (node_r[hb_pkg::LEAF_BITS-1:0] < total_r) begin
        res_nxt.child_zero  = chq_r[hb_pkg::IDX_BITS-1:0];
        res_nxt.child_one   = chq_r[2*hb_pkg::IDX_BITS-1:hb_pkg::IDX_BITS];
        res_nxt.node_weight = cur_w;
      end
    end
  end

  assign sts.load_done  = ld_addr_r[hb_pkg::LEAF_BITS] && !pv_r;
  assign sts.scan_done  = sc_end_r && !sv_r;
  assign sts.multi_live = (alive_r > hb_pkg::IDX_BITS'(1));
  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_res        = out_res_r;

endmodule

/* src/huffman_tree_builder.sv */
// Huffman tree builder over a byte alphabet. A count word adds one hit of a
// byte to a saturating 256-entry histogram (read, then write of the count
// memory); it returns nothing. A read word returns one node of the last
// tree. A build word loads the histogram into the leaf weights, then for
// merge k scans nodes 0 to 255+k of the single-port weight memory for the
// two lightest live nodes and writes three words back. The histogram is
// cleared at the end of the load phase through per-entry valid flags, so no
// clearing pass runs. Ties are broken toward the lowest node index; internal
// nodes are numbered from 256 in the order they are made.
module huffman_tree_builder (
  input logic      clk,
  input logic      rst_n,
  hb_in_if.sink    in_ch,
  hb_out_if.source out_ch
);

  hb_pkg::cmd_t    cmd;
  hb_pkg::sts_t    sts;
  hb_pkg::result_t res;

  // sequencer: decode the input word and step through load, scan and merge
  hb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // memories, counters, compare logic and the result register
  hb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_mode   (in_ch.mode),
    .in_byte   (in_ch.byte_value),
    .in_node   (in_ch.node_index),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_res   (res)
  );

  // drive the result word
  assign out_ch.root_index     = res.root_index;
  assign out_ch.tree_empty     = res.tree_empty;
  assign out_ch.internal_count = res.internal_count;
  assign out_ch.child_zero     = res.child_zero;
  assign out_ch.child_one      = res.child_one;
  assign out_ch.node_weight    = res.node_weight;
  assign out_ch.node_is_leaf   = res.node_is_leaf;
  assign out_ch.leaf_in_tree   = res.leaf_in_tree;

  // no memory writes of the build phase while a new word can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(cmd.kill_a || cmd.kill_b || cmd.merge || cmd.load_run))
    else $error("build step active while input is ready");

  // a counted byte is written back in the next cycle
  a_count_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.mode == hb_pkg::MODE_COUNT)) |=> cmd.count_wr)
    else $error("count word not written back");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !cmd.out_load)
    else $error("result overwrote a pending word");

endmodule

/* bench/huffman_tree_scoreboard.sv */
module huffman_tree_scoreboard (
  input  logic   clk,
  input  logic   rst_n,
  hb_in_if       in_ch,
  hb_out_if      out_ch,
  output int     fail_count,
  output int     pending,
  output int     results_seen
);

  hb_pkg::count_t              hist     [hb_pkg::LEAF_SLOTS];
  hb_pkg::weight_t             wt       [hb_pkg::NODE_SLOTS];
  bit                          on_heap  [hb_pkg::NODE_SLOTS];
  logic [2*hb_pkg::IDX_BITS-1:0] kids   [hb_pkg::LEAF_SLOTS];
  hb_pkg::idx_t                root_m;
  logic                        empty_m;
  logic [7:0]                  total_m;
  hb_pkg::result_t             expected_q[$];
  int                          n_fail = 0;
  int                          n_seen = 0;

  localparam hb_pkg::weight_t WMAX = '1;

  initial begin
    for (int i = 0; i < hb_pkg::LEAF_SLOTS; i++) begin
      hist[i] = '0;
      kids[i] = '0;
    end
    for (int i = 0; i < hb_pkg::NODE_SLOTS; i++) begin
      wt[i]      = '0;
      on_heap[i] = 0;
    end
    root_m  = '0;
    empty_m = 1'b1;
    total_m = '0;
  end

  assign pending      = expected_q.size();
  assign fail_count   = n_fail;
  assign results_seen = n_seen;

  // lowest weight wins, lowest index on ties
  function automatic int lightest_node();
    int pick;
    pick = hb_pkg::NODE_SLOTS;
    for (int i = 0; i < hb_pkg::NODE_SLOTS; i++)
      if (on_heap[i] && (pick == hb_pkg::NODE_SLOTS || wt[i] < wt[pick])) pick = i;
    return pick;
  endfunction

  function automatic void merge_histogram();
    int made, nlive, last, a, b;
    logic [hb_pkg::WEIGHT_BITS:0] sum;
    made = 0; nlive = 0; last = 0;
    for (int i = 0; i < hb_pkg::NODE_SLOTS; i++) begin
      wt[i]      = (i < hb_pkg::SYMBOLS) ? hb_pkg::weight_t'(hist[i]) : '0;
      on_heap[i] = (i < hb_pkg::SYMBOLS) && (hist[i] != 0);
      if (on_heap[i]) begin
        nlive++;
        last = i;
      end
    end
    while (nlive > 1 && made < hb_pkg::LEAF_SLOTS) begin
      a = lightest_node();
      on_heap[a] = 0;
      b = lightest_node();
      on_heap[b] = 0;
      sum = {1'b0, wt[a]} + {1'b0, wt[b]};
      wt[hb_pkg::LEAF_SLOTS+made] = sum[hb_pkg::WEIGHT_BITS] ? WMAX
                                  : sum[hb_pkg::WEIGHT_BITS-1:0];
      on_heap[hb_pkg::LEAF_SLOTS+made] = 1;
      kids[made] = {hb_pkg::idx_t'(b), hb_pkg::idx_t'(a)};
      last = hb_pkg::LEAF_SLOTS + made;
      made++;
      nlive--;
    end
    total_m = made[7:0];
    empty_m = (nlive == 0);
    root_m  = (nlive == 0) ? '0 : hb_pkg::idx_t'(last);
    for (int i = 0; i < hb_pkg::LEAF_SLOTS; i++) hist[i] = '0;
  endfunction

  task automatic report(string field, logic [hb_pkg::WEIGHT_BITS-1:0] got,
                        logic [hb_pkg::WEIGHT_BITS-1:0] want);
    $display("mismatch on %s at %0t: got %0d, want %0d", field, $realtime, got, want);
    n_fail++;
  endtask

  // count into the model histogram, and predict on every accepted build or read word
  always @(posedge clk) begin
    hb_pkg::result_t r;
    hb_pkg::mode_t   m;
    int              idx;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      m   = hb_pkg::mode_t'(in_ch.mode);
      idx = in_ch.node_index;
      r   = '0;
      case (m)
        hb_pkg::MODE_COUNT: begin
          if (hist[in_ch.byte_value] != hb_pkg::COUNT_MAX)
            hist[in_ch.byte_value] = hist[in_ch.byte_value] + 1'b1;
        end
        hb_pkg::MODE_BUILD, hb_pkg::MODE_READ: begin
          if (m == hb_pkg::MODE_BUILD) merge_histogram();
          r.root_index     = root_m;
          r.tree_empty     = empty_m;
          r.internal_count = total_m;
          if (m == hb_pkg::MODE_READ) begin
            if (idx < hb_pkg::LEAF_SLOTS) begin
              r.node_weight  = wt[idx];
              r.node_is_leaf = 1'b1;
              r.leaf_in_tree = (wt[idx] != 0);
            end else if (idx - hb_pkg::LEAF_SLOTS < total_m) begin
              r.child_zero  = kids[idx-hb_pkg::LEAF_SLOTS][hb_pkg::IDX_BITS-1:0];
              r.child_one   = kids[idx-hb_pkg::LEAF_SLOTS][2*hb_pkg::IDX_BITS-1:hb_pkg::IDX_BITS];
              r.node_weight = wt[idx];
            end
          end
          expected_q = {expected_q, r};
        end
        default: ;
      endcase
    end
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin
    hb_pkg::result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_seen++;
      if (expected_q.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.root_index !== e.root_index)
          report("root_index", hb_pkg::WEIGHT_BITS'(out_ch.root_index),
                 hb_pkg::WEIGHT_BITS'(e.root_index));
        if (out_ch.tree_empty !== e.tree_empty)
          report("tree_empty", hb_pkg::WEIGHT_BITS'(out_ch.tree_empty),
                 hb_pkg::WEIGHT_BITS'(e.tree_empty));
        if (out_ch.internal_count !== e.internal_count)
          report("internal_count", hb_pkg::WEIGHT_BITS'(out_ch.internal_count),
                 hb_pkg::WEIGHT_BITS'(e.internal_count));
        if (out_ch.child_zero !== e.child_zero)
          report("child_zero", hb_pkg::WEIGHT_BITS'(out_ch.child_zero),
                 hb_pkg::WEIGHT_BITS'(e.child_zero));
        if (out_ch.child_one !== e.child_one)
          report("child_one", hb_pkg::WEIGHT_BITS'(out_ch.child_one),
                 hb_pkg::WEIGHT_BITS'(e.child_one));
        if (out_ch.node_weight !== e.node_weight)
          report("node_weight", out_ch.node_weight, e.node_weight);
        if (out_ch.node_is_leaf !== e.node_is_leaf)
          report("node_is_leaf", hb_pkg::WEIGHT_BITS'(out_ch.node_is_leaf),
                 hb_pkg::WEIGHT_BITS'(e.node_is_leaf));
        if (out_ch.leaf_in_tree !== e.leaf_in_tree)
          report("leaf_in_tree", hb_pkg::WEIGHT_BITS'(out_ch.leaf_in_tree),
                 hb_pkg::WEIGHT_BITS'(e.leaf_in_tree));
      end
    end
  end
endmodule

/* bench/tb_huffman_tree_builder.sv */
module tb_huffman_tree_builder;

  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst_n;
  int   fail_count, pending, results_seen;
  int   cycles = 0;
  int   words_sent, builds_sent;

  hb_in_if  in_ch ();
  hb_out_if out_ch ();

  huffman_tree_builder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  huffman_tree_scoreboard chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // mostly zero, sometimes a short gap, now and then a long stretch
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // watchdog: a run that hangs ends here as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: hold ready low for random stretches, with calm phases in between
  int stall_left;
  int calm_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      calm_left    <= 0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else if (calm_left > 0) begin
      calm_left    <= calm_left - 1;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      calm_left    <= $urandom_range(20, 200);
      out_ch.ready <= 1'b1;
    end else begin
      stall_left   <= gap_length();
      out_ch.ready <= 1'b0;
    end
  end

  // drive one word and hold it until it is taken
  task automatic send_word(hb_pkg::mode_t m, logic [7:0] b, logic [8:0] idx);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.byte_value <= b;
    in_ch.node_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (m == hb_pkg::MODE_BUILD) builds_sent++;
  endtask

  task automatic read_random_node(int span);
    logic [8:0] idx;
    case ($urandom_range(0, 3))
      0: idx = 9'($urandom_range(0, 511));
      1: idx = 9'($urandom_range(0, 255));
      default: idx = 9'(256 + $urandom_range(0, span));
    endcase
    send_word(hb_pkg::MODE_READ, 8'($urandom), idx);
  endtask

  initial begin
    logic [7:0] alphabet [12];
    int         nsym, ncount;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = hb_pkg::MODE_COUNT;
    in_ch.byte_value = '0;
    in_ch.node_index = '0;
    words_sent       = 0;
    builds_sent      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reads before any build, empty build, two-leaf and one-leaf trees
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd0);
    send_word(hb_pkg::MODE_READ, 8'hff, 9'd511);
    send_word(hb_pkg::MODE_BUILD, 8'h00, 9'd0);
    send_word(hb_pkg::MODE_COUNT, 8'h00, 9'd0);
    send_word(hb_pkg::MODE_COUNT, 8'hff, 9'd0);
    send_word(hb_pkg::MODE_COUNT, 8'hff, 9'd0);
    send_word(hb_pkg::MODE_NONE, 8'hff, 9'd300);
    send_word(hb_pkg::MODE_BUILD, 8'h00, 9'd0);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd256);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd255);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd0);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd257);
    send_word(hb_pkg::MODE_COUNT, 8'h07, 9'd0);
    send_word(hb_pkg::MODE_BUILD, 8'h00, 9'd0);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd7);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd256);

    // one full alphabet: every leaf live, 255 merges, many equal weights
    for (int i = 0; i < 256; i++) begin
      send_word(hb_pkg::MODE_COUNT, 8'(i), 9'h1ff);
      if (i % 3 == 0) send_word(hb_pkg::MODE_COUNT, 8'(i), 9'd0);
    end
    send_word(hb_pkg::MODE_BUILD, 8'h00, 9'd0);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd510);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd511);
    send_word(hb_pkg::MODE_READ, 8'h00, 9'd300);

    // random: mostly count bursts over a small alphabet, build, then reads
    while (words_sent < 1150) begin
      if ($urandom_range(0, 4) != 0) begin
        nsym   = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        ncount = $urandom_range(nsym, 3 * nsym + 4);
        for (int i = 0; i < nsym; i++) alphabet[i] = 8'($urandom);
        for (int i = 0; i < ncount; i++)
          send_word(hb_pkg::MODE_COUNT, alphabet[$urandom_range(0, nsym - 1)], 9'($urandom));
        send_word(hb_pkg::MODE_BUILD, 8'($urandom), 9'($urandom));
        repeat ($urandom_range(2, 6)) read_random_node(nsym);
      end else begin
        // noise: any mode, any fields
        repeat ($urandom_range(1, 6))
          send_word(hb_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom), 9'($urandom));
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then allow a short tail for stray words
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d words including %0d builds; %0d result words checked",
             words_sent, builds_sent, results_seen);
    $display("covered empty, one-leaf, full-alphabet and small random trees");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
